FILE: hw/rtl/skvt_pkg.sv
package skvt_pkg;

  // field widths of the stream words
  localparam int MODE_W     = 2;
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CNT_OUT_W  = 5;
  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = 40;
  localparam int PAIR_W     = KEY_W + VAL_W;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // request codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // register index
  localparam logic REG_ORDER_MODE = 1'b0;

  // sequencer steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] ST_SCAN0   = 4'd1;
  localparam logic [STEP_W-1:0] ST_CMP     = 4'd2;
  localparam logic [STEP_W-1:0] ST_DISP    = 4'd3;
  localparam logic [STEP_W-1:0] ST_REPL    = 4'd4;
  localparam logic [STEP_W-1:0] ST_INS0    = 4'd5;
  localparam logic [STEP_W-1:0] ST_INS_SH  = 4'd6;
  localparam logic [STEP_W-1:0] ST_INS_WR  = 4'd7;
  localparam logic [STEP_W-1:0] ST_REM0    = 4'd8;
  localparam logic [STEP_W-1:0] ST_REM_SH  = 4'd9;
  localparam logic [STEP_W-1:0] ST_REM_END = 4'd10;
  localparam logic [STEP_W-1:0] ST_FIN     = 4'd11;

  // datapath actions
  typedef logic [3:0] act_t;
  localparam act_t A_NONE   = 4'd0;
  localparam act_t A_LOAD   = 4'd1;
  localparam act_t A_SCAN0  = 4'd2;
  localparam act_t A_CMP    = 4'd3;
  localparam act_t A_DISP   = 4'd4;
  localparam act_t A_REPL   = 4'd5;
  localparam act_t A_INS0   = 4'd6;
  localparam act_t A_INS_SH = 4'd7;
  localparam act_t A_INS_WR = 4'd8;
  localparam act_t A_REM0   = 4'd9;
  localparam act_t A_REM_SH = 4'd10;
  localparam act_t A_DEC    = 4'd11;
  localparam act_t A_FIN    = 4'd12;

  // jump kinds
  typedef logic [1:0] jmp_t;
  localparam jmp_t J_GOTO = 2'd0;  // always to target
  localparam jmp_t J_IF   = 2'd1;  // cond ? target : next step
  localparam jmp_t J_HOLD = 2'd2;  // cond ? stay : target
  localparam jmp_t J_DISP = 2'd3;  // target picked from request, scan outcome and fill state

  // branch conditions
  typedef logic [2:0] cond_t;
  localparam cond_t C_NO_FIRE  = 3'd0;
  localparam cond_t C_SCAN_END = 3'd1;
  localparam cond_t C_CMP_LOOP = 3'd2;
  localparam cond_t C_INS_NONE = 3'd3;
  localparam cond_t C_INS_MORE = 3'd4;
  localparam cond_t C_REM_NONE = 3'd5;
  localparam cond_t C_REM_MORE = 3'd6;
  localparam cond_t C_OUT_BUSY = 3'd7;

  typedef struct packed {
    act_t              act;
    jmp_t              jmp;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  function automatic ucode_t skvt_ucode(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      ST_IDLE:    w = '{A_LOAD,   J_HOLD, C_NO_FIRE,  ST_SCAN0};
      ST_SCAN0:   w = '{A_SCAN0,  J_IF,   C_SCAN_END, ST_DISP};
      ST_CMP:     w = '{A_CMP,    J_HOLD, C_CMP_LOOP, ST_DISP};
      ST_DISP:    w = '{A_DISP,   J_DISP, C_NO_FIRE,  ST_FIN};
      ST_REPL:    w = '{A_REPL,   J_GOTO, C_NO_FIRE,  ST_FIN};
      ST_INS0:    w = '{A_INS0,   J_IF,   C_INS_NONE, ST_INS_WR};
      ST_INS_SH:  w = '{A_INS_SH, J_HOLD, C_INS_MORE, ST_INS_WR};
      ST_INS_WR:  w = '{A_INS_WR, J_GOTO, C_NO_FIRE,  ST_FIN};
      ST_REM0:    w = '{A_REM0,   J_IF,   C_REM_NONE, ST_REM_END};
      ST_REM_SH:  w = '{A_REM_SH, J_HOLD, C_REM_MORE, ST_REM_END};
      ST_REM_END: w = '{A_DEC,    J_GOTO, C_NO_FIRE,  ST_FIN};
      ST_FIN:     w = '{A_FIN,    J_HOLD, C_OUT_BUSY, ST_IDLE};
      default:    w = '{A_NONE,   J_GOTO, C_NO_FIRE,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/sorted_key_value_table_unit.sv
// Sorted key-value table: holds up to TABLE_DEPTH pairs of signed 32-bit keys and values in
// key order (ascending, or descending when order_mode is 1). Each word on the input stream
// is an add-or-replace, a search or a remove (in_tuser); each gives exactly one result word
// with the found flag, the old value (0 when not found), the full status and the entry count.
// A request walks a small microcode program over one table memory with a read port and a
// write port, one entry per cycle: it loads the request, scans the entries in key order,
// then where needed goes through a replace, an insert (shift entries up, then write) or a
// remove (shift entries down, then lower the count), and finally waits in the finish step
// until the previous result has left. Scan and shift together touch at most TABLE_DEPTH
// entries. The table needs no clearing after reset. Keys are not re-sorted when order_mode
// changes; set it while the table is empty. The next request is taken while the last
// result still waits on out_tready.
module sorted_key_value_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [skvt_pkg::IN_DATA_W-1:0]  in_tdata,   // key[31:0], value[63:32]
  input  logic [skvt_pkg::MODE_W-1:0]     in_tuser,   // mode[1:0]
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [skvt_pkg::OUT_DATA_W-1:0] out_tdata,  // old_value[31:0], entry_count[36:32]
  output logic [1:0]                      out_tuser,  // found[0], status[1]
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [skvt_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [skvt_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [skvt_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready
);

  import skvt_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  // sequencer
  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucode_t            uw;
  logic              cond;

  // request and scan state
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic              hit_r, hit_nxt;
  logic              status_r, status_nxt;
  logic [VAL_W-1:0]  old_r, old_nxt;
  logic              order_r, order_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_found_r, out_found_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [VAL_W-1:0]     out_old_r, out_old_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // table memory
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [PAIR_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  raddr_full, waddr_full;

  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic [CNT_W-1:0] pos_inc, j_inc, j_dec, cnt_dec;
  logic [31:0]      count_ext;
  logic             in_fire, cfg_wr, scan_go, key_eq, out_busy;

  assign uw        = skvt_ucode(pc_r);
  assign in_tready = (pc_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_val = ram_rdata[PAIR_W-1:KEY_W];

  assign pos_inc   = pos_r + 1'b1;
  assign j_inc     = j_r + 1'b1;
  assign j_dec     = j_r - 1'b1;
  assign cnt_dec   = count_r - 1'b1;
  assign count_ext = 32'(count_r);

  // scan goes on while the stored key stands before or equal to the request key
  assign scan_go = order_r ? ($signed(key_r) <= $signed(rd_key))
                           : ($signed(rd_key) <= $signed(key_r));
  assign key_eq  = (rd_key == key_r);

  always_comb begin
    case (uw.cond)
      C_NO_FIRE:  cond = !in_fire;
      C_SCAN_END: cond = (pos_r >= count_r) || (mode_r == MODE_NONE);
      C_CMP_LOOP: cond = scan_go && !key_eq && (pos_inc < count_r);
      C_INS_NONE: cond = (count_r == pos_r);
      C_INS_MORE: cond = (j_r != pos_r);
      C_REM_NONE: cond = (pos_inc >= count_r);
      C_REM_MORE: cond = (j_inc < count_r);
      C_OUT_BUSY: cond = out_busy;
      default:    cond = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.jmp)
      J_GOTO: pc_nxt = uw.target;
      J_IF:   pc_nxt = cond ? uw.target : pc_r + 1'b1;
      J_HOLD: pc_nxt = cond ? pc_r : uw.target;
      J_DISP: begin
        case (mode_r)
          MODE_ADD: begin
            if (hit_r) begin
              pc_nxt = ST_REPL;
            end else if (count_r == CNT_FULL) begin
              pc_nxt = ST_FIN;
            end else begin
              pc_nxt = ST_INS0;
            end
          end
          MODE_REMOVE: pc_nxt = hit_r ? ST_REM0 : ST_FIN;
          default:     pc_nxt = ST_FIN;
        endcase
      end
      default: pc_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    j_nxt      = j_r;
    hit_nxt    = hit_r;
    status_nxt = status_r;
    old_nxt    = old_r;
    raddr_full = pos_r;
    waddr_full = pos_r;
    ram_we     = 1'b0;
    ram_wdata  = {val_r, key_r};

    out_valid_nxt  = out_valid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_old_nxt    = out_old_r;
    out_cnt_nxt    = out_cnt_r;

    case (uw.act)
      A_LOAD: begin
        if (in_fire) begin
          mode_nxt   = in_tuser;
          key_nxt    = in_tdata[KEY_W-1:0];
          val_nxt    = in_tdata[IN_DATA_W-1:KEY_W];
          pos_nxt    = '0;
          hit_nxt    = 1'b0;
          status_nxt = 1'b0;
          old_nxt    = '0;
        end
      end
      A_SCAN0: raddr_full = pos_r;
      A_CMP: begin
        raddr_full = pos_inc;
        if (scan_go && key_eq) begin
          hit_nxt = 1'b1;
          old_nxt = rd_val;
        end else if (scan_go) begin
          pos_nxt = pos_inc;
        end
      end
      A_DISP: status_nxt = (mode_r == MODE_ADD) && !hit_r && (count_r == CNT_FULL);
      A_REPL: ram_we = 1'b1;
      A_INS0: begin
        j_nxt      = cnt_dec;
        raddr_full = cnt_dec;
      end
      A_INS_SH: begin
        // move entry j up by one, fetch the one below
        ram_we     = 1'b1;
        waddr_full = j_inc;
        ram_wdata  = ram_rdata;
        j_nxt      = j_dec;
        raddr_full = j_dec;
      end
      A_INS_WR: begin
        ram_we    = 1'b1;
        count_nxt = count_r + 1'b1;
      end
      A_REM0: begin
        j_nxt      = pos_inc;
        raddr_full = pos_inc;
      end
      A_REM_SH: begin
        // move entry j down by one, fetch the one above
        ram_we     = 1'b1;
        waddr_full = j_dec;
        ram_wdata  = ram_rdata;
        j_nxt      = j_inc;
        raddr_full = j_inc;
      end
      A_DEC: count_nxt = cnt_dec;
      A_FIN: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = hit_r;
          out_status_nxt = status_r;
          out_old_nxt    = old_r;
          out_cnt_nxt    = count_ext[CNT_OUT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign ram_raddr = raddr_full[AW-1:0];
  assign ram_waddr = waddr_full[AW-1:0];

  skvt_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign order_nxt  = (cfg_wr && (cfg_paddr[2] == REG_ORDER_MODE)) ? cfg_pwdata[0] : order_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_ORDER_MODE) ? CFG_DW'(order_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      j_r         <= '0;
      hit_r       <= 1'b0;
      status_r    <= 1'b0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      j_r         <= j_nxt;
      hit_r       <= hit_nxt;
      status_r    <= status_nxt;
      order_r     <= order_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    old_r        <= old_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_old_r    <= out_old_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VAL_W - CNT_OUT_W){1'b0}}, out_cnt_r, out_old_r};
  assign out_tuser  = {out_status_r, out_found_r};

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above table depth");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == ST_INS_WR |-> count_r < CNT_FULL)
    else $error("insert into a full table");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> waddr_full <= count_r)
    else $error("table write beyond the filled region");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r == ST_FIN))
    else $error("result word loaded outside the finish step");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> !out_found_r && out_cnt_r == CNT_OUT_W'(TABLE_DEPTH))
    else $error("full status on a found key or with a count below the depth");
`endif

endmodule

FILE: hw/rtl/skvt_ram.sv
module skvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
